### design/mmrq_pkg.sv
package mmrq_pkg;

  localparam int DEPTH    = 64;
  localparam int OCC_W    = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 31;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast from the controller to every cell in the row
  typedef struct packed {
    logic   push;
    logic   pop;
    value_t value;
  } cell_ctrl_t;

endpackage

### design/min_max_range_queue.sv
// Queue of signed values that reports the spread (largest minus smallest) of
// its contents. Each transaction carries one operation: push a value, pop the
// oldest, or query the spread. busy is always low, so a transaction can be
// started in every cycle; each one produces exactly one result, shown with
// strobe high for one cycle, in the cycle after the transaction was accepted.
// The receiver cannot stall, and none is needed: results leave in order at
// the rate transactions arrive. A pop or query on an empty queue gives the
// empty status, a push to a full queue gives the full status and changes
// nothing. spread is nonzero only on a successful query; unused operation
// codes complete with done status. The queue is a row of cells, oldest first;
// each cell keeps its value and the running bounds of itself and all younger
// cells, so the bounds of the whole queue sit in the head cell at all times.
// Cell contents are not cleared by reset; only the occupancy count and strobe are.
module min_max_range_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mmrq_pkg::FUNC_W-1:0]           func,
  input  mmrq_pkg::value_t                      value,
  output logic                                  strobe,
  output logic [mmrq_pkg::STATUS_W-1:0]         status,
  output logic [mmrq_pkg::VALUE_W-1:0]          spread
);

  logic [mmrq_pkg::OCC_W-1:0]     occupancy;
  logic [mmrq_pkg::OCC_W-1:0]     occupancy_next;
  logic [mmrq_pkg::STATUS_W-1:0]  status_next;
  logic [mmrq_pkg::VALUE_W-1:0]   spread_next;
  logic                           is_empty;
  logic                           is_full;
  mmrq_pkg::cell_ctrl_t           ctrl;

  mmrq_pkg::value_t cell_value [mmrq_pkg::DEPTH];
  mmrq_pkg::value_t cell_min   [mmrq_pkg::DEPTH];
  mmrq_pkg::value_t cell_max   [mmrq_pkg::DEPTH];
  logic [mmrq_pkg::VALUE_W-1:0] head_min_bits;
  logic [mmrq_pkg::VALUE_W-1:0] head_max_bits;

  // No operation ever holds the interface busy
  assign busy = 1'b0;

  assign is_empty = (occupancy == '0);
  assign is_full  = (occupancy == mmrq_pkg::OCC_W'(mmrq_pkg::DEPTH));

  assign head_min_bits = cell_min[0];
  assign head_max_bits = cell_max[0];

  // Decode the transaction into the broadcast, the new count and the result
  always_comb begin
    ctrl.push      = 1'b0;
    ctrl.pop       = 1'b0;
    ctrl.value     = value;
    occupancy_next = occupancy;
    status_next    = mmrq_pkg::STATUS_DONE;
    spread_next    = '0;
    if (start) begin
      unique case (func)
        mmrq_pkg::FUNC_PUSH: begin
          if (is_full) begin
            status_next = mmrq_pkg::STATUS_FULL;
          end else begin
            ctrl.push      = 1'b1;
            occupancy_next = occupancy + 1'b1;
          end
        end
        mmrq_pkg::FUNC_POP: begin
          if (is_empty) begin
            status_next = mmrq_pkg::STATUS_EMPTY;
          end else begin
            ctrl.pop       = 1'b1;
            occupancy_next = occupancy - 1'b1;
          end
        end
        mmrq_pkg::FUNC_QUERY: begin
          if (is_empty) begin
            status_next = mmrq_pkg::STATUS_EMPTY;
          end else begin
            // Wraps at 31 bits; the true spread always fits
            spread_next = head_max_bits - head_min_bits;
          end
        end
        default: begin
          status_next = mmrq_pkg::STATUS_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      strobe    <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      strobe    <= start;
    end
  end

  // Result payload: registered every cycle from the decode of that cycle's inputs
  always_ff @(posedge clk) begin
    status <= status_next;
    spread <= spread_next;
  end

  // Row of cells, oldest at index 0; each hands its contents down on a pop
  for (genvar i = 0; i < mmrq_pkg::DEPTH; i++) begin : g_cell
    logic             occupied;
    logic             tail;
    mmrq_pkg::value_t up_value;
    mmrq_pkg::value_t up_min;
    mmrq_pkg::value_t up_max;

    assign occupied = (mmrq_pkg::OCC_W'(i) < occupancy);
    assign tail     = (mmrq_pkg::OCC_W'(i) == occupancy);

    if (i == mmrq_pkg::DEPTH - 1) begin : g_last
      // Nothing younger: the last cell loads zeros on a pop
      assign up_value = '0;
      assign up_min   = '0;
      assign up_max   = '0;
    end else begin : g_inner
      assign up_value = cell_value[i+1];
      assign up_min   = cell_min[i+1];
      assign up_max   = cell_max[i+1];
    end

    mmrq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occupied),
      .tail     (tail),
      .up_value (up_value),
      .up_min   (up_min),
      .up_max   (up_max),
      .value    (cell_value[i]),
      .ymin     (cell_min[i]),
      .ymax     (cell_max[i])
    );
  end

endmodule

### design/mmrq_cell.sv
module mmrq_cell (
  input  logic                clk,
  input  mmrq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                tail,
  input  mmrq_pkg::value_t    up_value,
  input  mmrq_pkg::value_t    up_min,
  input  mmrq_pkg::value_t    up_max,
  output mmrq_pkg::value_t    value,
  output mmrq_pkg::value_t    ymin,
  output mmrq_pkg::value_t    ymax
);

  // Bounds cover this cell and every younger one: fold a pushed value in,
  // load it when this cell becomes the tail, take the neighbour's on a pop.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      value <= up_value;
      ymin  <= up_min;
      ymax  <= up_max;
    end else if (ctrl.push) begin
      if (tail) begin
        value <= ctrl.value;
        ymin  <= ctrl.value;
        ymax  <= ctrl.value;
      end else if (occupied) begin
        if (ctrl.value < ymin) begin
          ymin <= ctrl.value;
        end
        if (ctrl.value > ymax) begin
          ymax <= ctrl.value;
        end
      end
    end
  end

endmodule
